@@ src/sobel_edge_magnitude_core_defines.svh @@
// Assertion macros shared by the Sobel edge magnitude core.
`ifndef SOBEL_EDGE_MAGNITUDE_CORE_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SEM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("%m failed");
`define SEM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m failed");
`else
`define SEM_ASSERT(lbl, clk, rstn, prop)
`define SEM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ src/sem_pkg.sv @@
// Shared types and constants of the Sobel edge magnitude core.
package sem_pkg;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 11;
  localparam int ROW_W      = 11;
  localparam int OROW_W     = 10;
  localparam int MAXV_W     = 8;
  localparam int MAX_HEIGHT = 1024;

  localparam logic [CFG_ADDR_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAXVAL = 2'd2;

  localparam logic [CFG_DATA_W-1:0] RST_WIDTH  = 11'd640;
  localparam logic [CFG_DATA_W-1:0] RST_HEIGHT = 11'd480;
  localparam logic [MAXV_W-1:0]     RST_MAXVAL = 8'd255;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WIN,
    ST_GRAD,
    ST_SQR,
    ST_ROOT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic read;
    logic update;
    logic grad;
    logic square;
    logic root_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic drop;
    logic emit;
    logic root_last;
    logic out_free;
  } sts_t;

endpackage

@@ src/sem_ctrl.sv @@
// Controller state machine sequencing one transaction through the datapath.
`include "sobel_edge_magnitude_core_defines.svh"
module sem_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output sem_pkg::cmd_t cmd,
  input  sem_pkg::sts_t sts
);

  sem_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sem_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      sem_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = sem_pkg::ST_READ;
        end
      end
      sem_pkg::ST_READ: begin
        cmd.read  = 1'b1;
        state_nxt = sts.drop ? sem_pkg::ST_IDLE : sem_pkg::ST_WIN;
      end
      sem_pkg::ST_WIN: begin
        cmd.update = 1'b1;
        state_nxt  = sts.emit ? sem_pkg::ST_GRAD : sem_pkg::ST_IDLE;
      end
      sem_pkg::ST_GRAD: begin
        cmd.grad  = 1'b1;
        state_nxt = sem_pkg::ST_SQR;
      end
      sem_pkg::ST_SQR: begin
        cmd.square = 1'b1;
        state_nxt  = sem_pkg::ST_ROOT;
      end
      sem_pkg::ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (sts.root_last) begin
          state_nxt = sem_pkg::ST_OUT;
        end
      end
      sem_pkg::ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = sem_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sem_pkg::ST_IDLE;
      end
    endcase
  end

  `SEM_ASSERT_NEXT(a_capture_read, clk, rst_n, cmd.capture, state_r == sem_pkg::ST_READ)
  `SEM_ASSERT_NEXT(a_root_hold, clk, rst_n,
                   (state_r == sem_pkg::ST_ROOT) && !sts.root_last,
                   state_r == sem_pkg::ST_ROOT)

endmodule

@@ src/sem_datapath.sv @@
// Datapath: line stores, 3x3 window, gradients, iterative square root, output register.
`include "sobel_edge_magnitude_core_defines.svh"
module sem_datapath #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sem_pkg::cmd_t                       cmd,
  output sem_pkg::sts_t                       sts,
  input  logic [7:0]                          in_tdata,
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [31:0]                         out_tdata,
  output logic                                out_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sem_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [sem_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int P    = PIXEL_BITS;
  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int WWA  = $clog2(MAX_WIDTH + 1);
  localparam int WW   = (WWA > sem_pkg::CFG_DATA_W) ? WWA : sem_pkg::CFG_DATA_W;
  localparam int AXW  = P + 2;
  localparam int RW   = P + 3;
  localparam int SW   = 2 * RW;
  localparam int CNTW = $clog2(RW);
  localparam int EW   = P + 8;
  localparam int RWD  = sem_pkg::ROW_W;

  logic [sem_pkg::CFG_DATA_W-1:0] frame_width_r, frame_height_r;
  logic [sem_pkg::MAXV_W-1:0]     max_value_r;

  logic [P-1:0] mem_a [MAX_WIDTH];
  logic [P-1:0] mem_b [MAX_WIDTH];
  logic [P-1:0] rd_a_r, rd_b_r;

  logic [P-1:0] win_r   [9];
  logic [P-1:0] win_nxt [9];
  logic [P-1:0] ewin_r  [9];
  logic [P-1:0] ewin_nxt[9];

  logic [AW-1:0]             in_col_r, out_col_r, c_r, c_nxt;
  logic [RWD-1:0]            in_row_r;
  logic [sem_pkg::OROW_W-1:0] out_row_r;
  logic                      op_r;
  logic [P-1:0]              val_r;
  logic [EW-1:0]             pix_ext;

  logic [WW-1:0]  fw_ext, eff_w;
  logic [RWD-1:0] eff_h;
  logic [WW:0]    in_nc, out_nc;
  logic [RWD-1:0] out_row_inc;
  logic           last, emit, restart_cfg;
  logic [P-1:0]   top, mid, bot;

  logic [AXW-1:0] ax_r, ay_r, gxp, gxn, gyp, gyn;
  logic [2*AXW-1:0] sqx, sqy;
  logic [SW-1:0]  v_r, res_r, bit_r;
  logic [SW:0]    trial;
  logic [CNTW-1:0] cnt_r;
  logic [7:0]     edge_val;

  logic [AW-1:0]             ox_r;
  logic [sem_pkg::OROW_W-1:0] oy_r;
  logic                      olast_r;
  logic [AW+9:0]             ox_ext;
  logic                      out_valid_r;
  logic [31:0]               out_data_r;
  logic                      out_last_r;

  assign fw_ext = WW'(frame_width_r);
  always_comb begin
    if (fw_ext == '0) begin
      eff_w = WW'(1);
    end else if (fw_ext > WW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = fw_ext;
    end
    if (frame_height_r == '0) begin
      eff_h = RWD'(1);
    end else if (frame_height_r > RWD'(sem_pkg::MAX_HEIGHT)) begin
      eff_h = RWD'(sem_pkg::MAX_HEIGHT);
    end else begin
      eff_h = frame_height_r;
    end
  end

  assign c_nxt   = (WW'(in_col_r) >= eff_w) ? '0 : in_col_r;
  assign pix_ext = EW'(in_tdata);

  assign top = (in_row_r >= RWD'(2)) ? rd_b_r : '0;
  assign mid = (in_row_r >= RWD'(1)) ? rd_a_r : '0;
  assign bot = (in_row_r < eff_h) ? val_r : '0;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (c_r == '0) begin
        ewin_nxt[k*3+0] = win_r[k*3+1];
        ewin_nxt[k*3+1] = win_r[k*3+2];
        ewin_nxt[k*3+2] = '0;
        win_nxt[k*3+0]  = '0;
        win_nxt[k*3+1]  = '0;
      end else begin
        win_nxt[k*3+0]  = win_r[k*3+1];
        win_nxt[k*3+1]  = win_r[k*3+2];
        ewin_nxt[k*3+0] = win_r[k*3+1];
        ewin_nxt[k*3+1] = win_r[k*3+2];
        ewin_nxt[k*3+2] = '0;
      end
    end
    win_nxt[2] = top;
    win_nxt[5] = mid;
    win_nxt[8] = bot;
    if (c_r != '0) begin
      ewin_nxt[2] = top;
      ewin_nxt[5] = mid;
      ewin_nxt[8] = bot;
    end
  end

  assign emit        = (c_r == '0) ? (in_row_r >= RWD'(2)) : (in_row_r >= RWD'(1));
  assign out_nc      = {1'b0, WW'(out_col_r)} + (WW+1)'(1);
  assign in_nc       = {1'b0, WW'(c_r)} + (WW+1)'(1);
  assign out_row_inc = RWD'(out_row_r) + RWD'(1);
  assign last        = (out_nc >= {1'b0, eff_w}) && (out_row_inc >= eff_h);
  assign restart_cfg = cfg_valid && ((cfg_addr == sem_pkg::CFG_WIDTH) ||
                                     (cfg_addr == sem_pkg::CFG_HEIGHT));

  assign gxp = AXW'(ewin_r[2]) + {ewin_r[5], 1'b0} + AXW'(ewin_r[8]);
  assign gxn = AXW'(ewin_r[0]) + {ewin_r[3], 1'b0} + AXW'(ewin_r[6]);
  assign gyp = AXW'(ewin_r[6]) + {ewin_r[7], 1'b0} + AXW'(ewin_r[8]);
  assign gyn = AXW'(ewin_r[0]) + {ewin_r[1], 1'b0} + AXW'(ewin_r[2]);
  assign sqx = ax_r * ax_r;
  assign sqy = ay_r * ay_r;
  assign trial = {1'b0, res_r} + {1'b0, bit_r};
  assign edge_val = (res_r > SW'(max_value_r)) ? max_value_r : res_r[7:0];
  assign ox_ext = (AW+10)'(ox_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= sem_pkg::RST_WIDTH;
      frame_height_r <= sem_pkg::RST_HEIGHT;
      max_value_r    <= sem_pkg::RST_MAXVAL;
      in_col_r       <= '0;
      in_row_r       <= '0;
      out_col_r      <= '0;
      out_row_r      <= '0;
      out_valid_r    <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_addr)
          sem_pkg::CFG_WIDTH:  frame_width_r  <= cfg_data;
          sem_pkg::CFG_HEIGHT: frame_height_r <= cfg_data;
          sem_pkg::CFG_MAXVAL: max_value_r    <= cfg_data[sem_pkg::MAXV_W-1:0];
          default: ;
        endcase
      end
      if (restart_cfg || (cmd.update && emit && last)) begin
        in_col_r  <= '0;
        in_row_r  <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
        for (int i = 0; i < 9; i++) begin
          win_r[i] <= '0;
        end
      end else if (cmd.update) begin
        for (int i = 0; i < 9; i++) begin
          win_r[i] <= win_nxt[i];
        end
        if (in_nc >= {1'b0, eff_w}) begin
          in_col_r <= '0;
          in_row_r <= in_row_r + RWD'(1);
        end else begin
          in_col_r <= in_nc[AW-1:0];
        end
        if (emit) begin
          if (out_nc >= {1'b0, eff_w}) begin
            out_col_r <= '0;
            out_row_r <= out_row_r + sem_pkg::OROW_W'(1);
          end else begin
            out_col_r <= out_nc[AW-1:0];
          end
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_tuser;
      val_r <= pix_ext[P-1:0];
    end
    if (cmd.read) begin
      c_r    <= c_nxt;
      rd_a_r <= mem_a[c_nxt];
      rd_b_r <= mem_b[c_nxt];
    end
    if (cmd.update && !(emit && last)) begin
      mem_a[c_r] <= bot;
      mem_b[c_r] <= rd_a_r;
    end
    if (cmd.update && emit) begin
      for (int i = 0; i < 9; i++) begin
        ewin_r[i] <= ewin_nxt[i];
      end
      ox_r    <= out_col_r;
      oy_r    <= out_row_r;
      olast_r <= last;
    end
    if (cmd.grad) begin
      ax_r <= (gxp >= gxn) ? gxp - gxn : gxn - gxp;
      ay_r <= (gyp >= gyn) ? gyp - gyn : gyn - gyp;
    end
    if (cmd.square) begin
      v_r   <= SW'(sqx) + SW'(sqy);
      res_r <= '0;
      bit_r <= SW'(1) << (SW - 2);
      cnt_r <= CNTW'(RW - 1);
    end else if (cmd.root_step) begin
      if ({1'b0, v_r} >= trial) begin
        v_r   <= v_r - trial[SW-1:0];
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
      cnt_r <= cnt_r - CNTW'(1);
    end
    if (cmd.out_load) begin
      out_data_r <= {4'b0, oy_r, ox_ext[9:0], edge_val};
      out_last_r <= olast_r;
    end
  end

  assign sts.drop      = (op_r == sem_pkg::OP_FLUSH) && (in_row_r < eff_h);
  assign sts.emit      = emit;
  assign sts.root_last = (cnt_r == '0);
  assign sts.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign cfg_ready  = 1'b1;

  `SEM_ASSERT_NEXT(a_load_valid, clk, rst_n, cmd.out_load, out_valid_r)
  `SEM_ASSERT(a_row_bound, clk, rst_n, (12'(in_row_r) <= (12'(eff_h) + 12'd1)))

endmodule

@@ src/sobel_edge_magnitude_core.sv @@
// Sobel 3x3 edge magnitude core top level.
// A pixel transaction with a result passes the READ, WIN, GRAD, SQR, ROOT and OUT states before the result
// register loads; one transaction is in flight at a time, an item without a result leaves after WIN and an
// ignored flush after READ; the square root finds one bit per cycle and OUT waits for a free output register.
// Reset: synchronous active low; registers take their reset values, positions and window clear.
// Line stores are not cleared; rows above the frame are masked off.
module sobel_edge_magnitude_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] pixel
  input  logic                           in_tuser,   // [0] opcode
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [31:0]                    out_tdata,  // [7:0] edge_value, [17:8] out_x, [27:18] out_y
  output logic                           out_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sem_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data
);

  sem_pkg::cmd_t cmd;
  sem_pkg::sts_t sts;

  sem_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  sem_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

endmodule
